FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg
// Types and codes shared by the histogram bin count / CDF engine.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam logic [2:0] CMD_WRITE_EDGE = 3'd0;
  localparam logic [2:0] CMD_IMPORT     = 3'd1;
  localparam logic [2:0] CMD_COUNT      = 3'd2;
  localparam logic [2:0] CMD_CUM        = 3'd3;
  localparam logic [2:0] CMD_INV_CDF    = 3'd4;

  localparam logic [4:0]  EDGES_RESET  = 5'd16;
  localparam logic [16:0] FRAC_ONE     = 17'd65536;
  localparam int          PROD_W       = 81;

  typedef enum logic [2:0] {
    OP_WRITE, OP_IMPORT, OP_COUNT, OP_CUM, OP_INV, OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_STEP, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] sample_value;
    logic [3:0]         edge_index;
    logic [16:0]        target_fraction;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [4:0]         bin_index;
    logic [31:0]        bin_count;
    logic [31:0]        cumulative_count;
    logic [31:0]        total_count;
    logic signed [31:0] edge_value;
  } out_item_t;

  // Classified command as held in the queue between front and back.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [3:0]         edge_index;
    logic [16:0]        target;
  } cmd_t;

endpackage

FILE: src/hbc_front.sv
// ----------------------------------------------------------------------------
// hbc_front
// Accepts input transactions, decodes the command and clamps the fraction,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hbc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hbc_pkg::in_item_t in_item,
  output logic             q_valid_o,
  output hbc_pkg::cmd_t    q_head_o,
  input  logic             q_pop_i
);

  hbc_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  hbc_pkg::cmd_t dec;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_r != 2'd0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_head_o  = q_mem_r[rd_ptr_r];

  always_comb begin
    dec.value      = in_item.sample_value;
    dec.edge_index = in_item.edge_index;
    dec.target     = (in_item.target_fraction > hbc_pkg::FRAC_ONE) ?
                     hbc_pkg::FRAC_ONE : in_item.target_fraction;
    case (in_item.command)
      hbc_pkg::CMD_WRITE_EDGE: dec.op = hbc_pkg::OP_WRITE;
      hbc_pkg::CMD_IMPORT:     dec.op = hbc_pkg::OP_IMPORT;
      hbc_pkg::CMD_COUNT:      dec.op = hbc_pkg::OP_COUNT;
      hbc_pkg::CMD_CUM:        dec.op = hbc_pkg::OP_CUM;
      hbc_pkg::CMD_INV_CDF:    dec.op = hbc_pkg::OP_INV;
      default:                 dec.op = hbc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: src/hbc_back.sv
// ----------------------------------------------------------------------------
// hbc_back
// Executes queued commands: writes edges, walks edge table and counters one
// entry a cycle, updates counters on import, forms one result per command.
// ----------------------------------------------------------------------------
module hbc_back #(
  parameter int MAX_EDGES   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        cfg_edges_i,
  input  logic              q_valid_i,
  input  hbc_pkg::cmd_t     cmd_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output hbc_pkg::out_item_t res_o
);

  localparam int KW = $clog2(MAX_EDGES + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = COUNT_WIDTH;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[CW] ? {CW{1'b1}} : s[CW-1:0];
    end
  endfunction

  function automatic logic [31:0] clip32(input logic [CW-1:0] v);
    logic [63:0] w;
    begin
      w = 64'(v);
      clip32 = (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    end
  endfunction

  hbc_pkg::state_t state_r, state_nxt;
  hbc_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic [48:0]     plo_r, plo_nxt;
  logic [48:0]     phi_r, phi_nxt;
  logic [hbc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  hbc_pkg::out_item_t res_r, res_nxt;

  logic signed [31:0] edge_mem [MAX_EDGES];
  logic [CW-1:0]      cnt_mem  [MAX_EDGES+1];
  logic [MAX_EDGES:0] cnt_vld_r;
  logic signed [31:0] edge_rd_r;
  logic [CW-1:0]      cnt_rd_r;
  logic               vld_rd_r;

  logic          edge_we;
  logic          cnt_we;
  logic [CW-1:0] cnt_wdata;
  logic [EW-1:0] edge_ra;
  logic [KW-1:0] n_use;
  logic [CW-1:0] cnt_k;
  logic [CW-1:0] acc_sum;
  logic [63:0]   t64;
  logic          is_end;
  logic          stop;
  logic          wr_ok;

  always_comb begin
    if (cfg_edges_i == 5'd0) begin
      n_use = KW'(1);
    end else if (int'(cfg_edges_i) > MAX_EDGES) begin
      n_use = KW'(MAX_EDGES);
    end else begin
      n_use = KW'(cfg_edges_i);
    end
  end

  assign cnt_k   = vld_rd_r ? cnt_rd_r : '0;
  assign acc_sum = sat_add(acc_r, cnt_k);
  assign t64     = 64'(total_r);
  assign is_end  = (k_r == n_use);
  assign wr_ok   = int'(cmd_i.edge_index) < int'(n_use);
  assign edge_ra = (int'(k_nxt) < MAX_EDGES) ? EW'(k_nxt) : EW'(MAX_EDGES - 1);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    total_nxt = total_r;
    prev_nxt  = prev_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    pop_o     = 1'b0;
    edge_we   = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = sat_add(cnt_k, CW'(1));
    res_valid_o = 1'b0;
    stop      = 1'b0;

    case (state_r)
      hbc_pkg::ST_IDLE: begin
        k_nxt   = '0;
        acc_nxt = '0;
        res_nxt = '0;
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cmd_nxt = cmd_i;
          case (cmd_i.op)
            hbc_pkg::OP_WRITE: begin
              edge_we        = wr_ok;
              res_nxt.status = !wr_ok;
              state_nxt      = hbc_pkg::ST_DONE;
            end
            hbc_pkg::OP_NONE:  state_nxt = hbc_pkg::ST_DONE;
            hbc_pkg::OP_INV:   state_nxt = hbc_pkg::ST_MUL_LO;
            default:           state_nxt = hbc_pkg::ST_STEP;
          endcase
        end
      end

      hbc_pkg::ST_MUL_LO: begin
        plo_nxt   = t64[31:0] * cmd_r.target;
        state_nxt = hbc_pkg::ST_MUL_HI;
      end

      hbc_pkg::ST_MUL_HI: begin
        phi_nxt   = t64[63:32] * cmd_r.target;
        state_nxt = hbc_pkg::ST_MUL_SUM;
      end

      hbc_pkg::ST_MUL_SUM: begin
        prod_nxt  = (hbc_pkg::PROD_W'(phi_r) << 32) + hbc_pkg::PROD_W'(plo_r);
        state_nxt = hbc_pkg::ST_STEP;
      end

      hbc_pkg::ST_STEP: begin
        if (cmd_r.op == hbc_pkg::OP_INV) begin
          stop = is_end ||
                 (hbc_pkg::PROD_W'({acc_sum, 16'h0000}) >= prod_r);
        end else begin
          stop = is_end || (cmd_r.value < edge_rd_r);
        end
        if (stop) begin
          res_nxt.bin_index   = 5'(k_r);
          res_nxt.bin_count   = clip32(cnt_k);
          res_nxt.total_count = clip32(total_r);
          case (cmd_r.op)
            hbc_pkg::OP_IMPORT: begin
              cnt_we              = 1'b1;
              total_nxt           = sat_add(total_r, CW'(1));
              res_nxt.bin_count   = clip32(cnt_wdata);
              res_nxt.total_count = clip32(total_nxt);
            end
            hbc_pkg::OP_CUM: res_nxt.cumulative_count = clip32(acc_sum);
            hbc_pkg::OP_INV: begin
              res_nxt.cumulative_count = clip32(acc_sum);
              res_nxt.edge_value       = (k_r == '0) ? edge_rd_r : prev_r;
            end
            default: ;
          endcase
          state_nxt = hbc_pkg::ST_DONE;
        end else begin
          k_nxt    = k_r + KW'(1);
          acc_nxt  = acc_sum;
          prev_nxt = edge_rd_r;
        end
      end

      hbc_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_nxt = hbc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = hbc_pkg::ST_IDLE;
    endcase
  end

  assign res_o = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hbc_pkg::ST_IDLE;
      total_r   <= '0;
      cnt_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cnt_we) begin
        cnt_vld_r[k_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    prev_r <= prev_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  // Tables: one write port, one registered read at the next walk address.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[EW'(cmd_i.edge_index)] <= cmd_i.value;
    end
    edge_rd_r <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[k_r] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[k_nxt];
    vld_rd_r <= cnt_vld_r[k_nxt];
  end

endmodule

FILE: src/histogram_bin_count_cdf_engine_core.sv
// ----------------------------------------------------------------------------
// histogram_bin_count_cdf_engine_core
// Histogram with programmable bin edges, saturating counters and CDF queries.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_item carries one command per transaction:
// write edge, import sample, count query, cumulative query or inverse CDF.
// Every command yields exactly one transaction on out_valid/out_stall/out_item.
// cfg_we/cfg_wdata set the number of edges in use; write it only while idle.
// A front end decodes commands into a two-entry queue; the back end walks the
// edge table and counter memory one entry per cycle.
// Steps: write edge and unknown commands pass from the queue straight to the
// result state; bin searches first walk the tables up to the selected bin;
// inverse CDF first forms the total*fraction product in the multiply states
// (MUL_LO, MUL_HI, MUL_SUM). The back end finishes one command, including its
// walk over the memories, before it pops the next.
// Reset (synchronous, rst_n low) clears all counters, the total, the queue
// and sets EDGES_RESET edges in use; edge values stay undefined until written.
// While out_stall is high the result holds; the queue keeps accepting until
// it fills, then in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module histogram_bin_count_cdf_engine_core #(
  parameter int MAX_EDGES   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hbc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  logic [4:0]         edges_r, edges_nxt;
  logic               q_valid;
  hbc_pkg::cmd_t      q_head;
  logic               q_pop;
  logic               res_valid;
  hbc_pkg::out_item_t res;
  logic               out_free;
  logic               load;
  logic               out_valid_r, out_valid_nxt;
  hbc_pkg::out_item_t out_item_r;

  hbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_valid_o (q_valid),
    .q_head_o  (q_head),
    .q_pop_i   (q_pop)
  );

  hbc_back #(
    .MAX_EDGES   (MAX_EDGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_edges_i (edges_r),
    .q_valid_i   (q_valid),
    .cmd_i       (q_head),
    .pop_o       (q_pop),
    .res_valid_o (res_valid),
    .res_ready_i (out_free),
    .res_o       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign load     = res_valid && out_free;

  always_comb begin
    edges_nxt     = cfg_we ? cfg_wdata : edges_r;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edges_r     <= hbc_pkg::EDGES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      edges_r     <= edges_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_NEXT(a_res_hold, res_valid && !out_free, res_valid,
               "back end dropped a result while output was busy")
  `ASSERT_IMPLY(a_bin_range, out_valid, int'(out_item.bin_index) <= MAX_EDGES,
                "bin index beyond overflow bin")
  `ASSERT_IMPLY(a_count_le_total, out_valid,
                out_item.bin_count <= out_item.total_count &&
                out_item.cumulative_count <= out_item.total_count,
                "count exceeds total")

endmodule

FILE: dv/hbc_scoreboard.sv
// ----------------------------------------------------------------------------
// hbc_scoreboard
// Watches the command, result and register ports of the histogram engine,
// keeps its own copy of edges, bin counters and total, predicts one result per
// command and compares each whole result, all fields at once, in order of arrival.
// ----------------------------------------------------------------------------
module hbc_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  hbc_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  hbc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  localparam int NUM_SLOTS = 16;
  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  logic [4:0]         edges_reg;
  logic signed [31:0] edge_slot [NUM_SLOTS];
  logic [31:0]        bin_tally [NUM_SLOTS + 1];
  logic [31:0]        sample_sum;
  hbc_pkg::out_item_t result_fifo [$];

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT_MAX : s[31:0];
  endfunction

  function automatic int active_edges();
    if (edges_reg == 5'd0) return 1;
    if (edges_reg > NUM_SLOTS) return NUM_SLOTS;
    return int'(edges_reg);
  endfunction

  function automatic int locate_bin(logic signed [31:0] v, int n);
    int k;
    for (k = 0; k < n; k++)
      if (v < edge_slot[k]) break;
    return k;
  endfunction

  // Advance the shadow state by one command and return its result.
  function automatic hbc_pkg::out_item_t apply_command(hbc_pkg::in_item_t c);
    hbc_pkg::out_item_t r;
    int n, k, i;
    logic [16:0] frac;
    logic [31:0] run;
    longint unsigned goal;
    r = '0;
    n = active_edges();
    frac = (c.target_fraction > hbc_pkg::FRAC_ONE) ? hbc_pkg::FRAC_ONE
                                                   : c.target_fraction;
    case (c.command)
      hbc_pkg::CMD_WRITE_EDGE: begin
        if (int'(c.edge_index) < n) edge_slot[c.edge_index] = c.sample_value;
        else r.status = 1'b1;
      end
      hbc_pkg::CMD_IMPORT: begin
        k = locate_bin(c.sample_value, n);
        bin_tally[k] = sat_inc(bin_tally[k], 32'd1);
        sample_sum = sat_inc(sample_sum, 32'd1);
        r.bin_index = k[4:0];
        r.bin_count = bin_tally[k];
        r.total_count = sample_sum;
      end
      hbc_pkg::CMD_COUNT, hbc_pkg::CMD_CUM: begin
        k = locate_bin(c.sample_value, n);
        r.bin_index = k[4:0];
        r.bin_count = bin_tally[k];
        r.total_count = sample_sum;
        if (c.command == hbc_pkg::CMD_CUM)
          for (i = 0; i <= k; i++)
            r.cumulative_count = sat_inc(r.cumulative_count, bin_tally[i]);
      end
      hbc_pkg::CMD_INV_CDF: begin
        goal = longint'(sample_sum) * longint'(frac);
        run = '0;
        for (k = 0; k < n; k++) begin
          run = sat_inc(run, bin_tally[k]);
          if ((longint'(run) << 16) >= goal) break;
        end
        if (k == n) run = sat_inc(run, bin_tally[n]);
        r.bin_index = k[4:0];
        r.bin_count = bin_tally[k];
        r.cumulative_count = run;
        r.total_count = sample_sum;
        r.edge_value = (k == 0) ? edge_slot[0] : edge_slot[k - 1];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    hbc_pkg::out_item_t want;
    if (!rst_n) begin
      edges_reg <= hbc_pkg::EDGES_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) edge_slot[i] = '0;
      for (int i = 0; i <= NUM_SLOTS; i++) bin_tally[i] = '0;
      sample_sum = '0;
      result_fifo.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) edges_reg <= cfg_wdata;
      if (in_valid && !in_stall)
        result_fifo.insert(result_fifo.size(), apply_command(in_item));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (result_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction: %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (out_item !== want) begin
            if (fail_count < 10)
              $display("result mismatch: expected %p, got %p", want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= result_fifo.size();
  end

  initial begin
    pending = 0;
    fail_count = 0;
    results_seen = 0;
  end
endmodule

FILE: dv/tb_histogram_bin_count_cdf_engine_core.sv
// ----------------------------------------------------------------------------
// tb_histogram_bin_count_cdf_engine_core
// Drives directed and random commands with random idle bursts on both sides,
// sweeps the edge count register through several phases and reports the
// scoreboard's verdict.
// ----------------------------------------------------------------------------
module tb_histogram_bin_count_cdf_engine_core;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  hbc_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  hbc_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [4:0]         cfg_wdata;
  int                 fail_count, pending, results_seen;
  bit                 quiet;
  bit                 calm_out;
  int                 stall_left;
  int                 edge_copy [16];
  int                 cmd_seen [8];

  histogram_bin_count_cdf_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  hbc_scoreboard scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet || calm_out) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_stall <= 1'b1;
    end
  end

  // Hold the transaction until accepted, then maybe drop valid for a burst.
  task automatic push_command(hbc_pkg::in_item_t c);
    int gap;
    in_valid <= 1'b1;
    in_item <= c;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    cmd_seen[c.command]++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (pending != 0 || in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic set_edge_count(logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic hbc_pkg::in_item_t make_cmd(logic [2:0] op, int v, int idx, int frac);
    hbc_pkg::in_item_t c;
    c.command = op;
    c.sample_value = v;
    c.edge_index = idx[3:0];
    c.target_fraction = frac[16:0];
    return c;
  endfunction

  // Write every edge slot with ascending edges; needs all slots in use.
  task automatic load_sorted_edges(int lo_span);
    int q [$];
    for (int i = 0; i < 16; i++)
      q.insert(q.size(), lo_span ? $urandom_range(0, 4000) - 2000 : int'($urandom));
    q.sort();
    for (int i = 0; i < 16; i++) begin
      edge_copy[i] = q[i];
      push_command(make_cmd(hbc_pkg::CMD_WRITE_EDGE, q[i], i,
                            $urandom_range(0, 131071)));
    end
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 3))
      0, 1: return edge_copy[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2;
      2: return int'($urandom);
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function automatic hbc_pkg::in_item_t random_cmd();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 40) op = hbc_pkg::CMD_IMPORT;
    else if (r < 55) op = hbc_pkg::CMD_COUNT;
    else if (r < 70) op = hbc_pkg::CMD_CUM;
    else if (r < 88) op = hbc_pkg::CMD_INV_CDF;
    else if (r < 94) op = hbc_pkg::CMD_WRITE_EDGE;
    else op = 3'($urandom_range(5, 7));
    return make_cmd(op, pick_value(), $urandom_range(0, 15),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(65536, 131071)
                                                : $urandom_range(0, 65536));
  endfunction

  initial begin
    logic [4:0] phase_edges [10] = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd16,
                                     5'd12, 5'd2, 5'd17, 5'd8, 5'd16};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    out_stall = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    calm_out = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all slots written first, extremes in slots 0 and 15, so every slot is written before any read.
    for (int i = 0; i < 16; i++) edge_copy[i] = -30000 + i * 4000;
    edge_copy[0] = 32'h8000_0000;
    edge_copy[15] = 32'h7FFF_FFFF;
    for (int i = 0; i < 16; i++)
      push_command(make_cmd(hbc_pkg::CMD_WRITE_EDGE, edge_copy[i], i, 0));
    push_command(make_cmd(hbc_pkg::CMD_INV_CDF, 0, 0, 65536));   // empty histogram
    push_command(make_cmd(hbc_pkg::CMD_IMPORT, 32'h8000_0000, 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_IMPORT, 32'h7FFF_FFFF, 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_IMPORT, edge_copy[3], 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_IMPORT, edge_copy[3] - 1, 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_COUNT, 32'h7FFF_FFFF, 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_CUM, 32'h7FFF_FFFF, 0, 0));   // overflow bin
    push_command(make_cmd(hbc_pkg::CMD_INV_CDF, 0, 0, 0));
    push_command(make_cmd(hbc_pkg::CMD_INV_CDF, 0, 0, 131071));      // fraction above one
    push_command(make_cmd(hbc_pkg::CMD_INV_CDF, 0, 0, 32768));
    push_command(make_cmd(3'd5, 5, 5, 5));
    push_command(make_cmd(3'd6, -1, 15, 131071));
    push_command(make_cmd(3'd7, 0, 0, 0));
    set_edge_count(5'd4);
    push_command(make_cmd(hbc_pkg::CMD_WRITE_EDGE, 0, 15, 0));       // beyond edges in use
    push_command(make_cmd(hbc_pkg::CMD_WRITE_EDGE, 0, 4, 0));

    // Random phases, each under the edge count that phase_edges gives it.
    for (int p = 0; p < 10; p++) begin
      if (p == 9) quiet = 1'b1;
      calm_out = (p == 4);
      set_edge_count(5'd16);
      if (p % 3 != 2) load_sorted_edges(p % 2);
      set_edge_count(phase_edges[p]);
      for (int i = 0; i < 175; i++) begin
        if (p == 3 && i == 80) drain();
        push_command(random_cmd());
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d results; writes %0d, imports %0d, count %0d, cum %0d, inverse %0d",
             results_seen, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4]);
    $display("unknown commands %0d over ten edge count settings",
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
